// ===== src/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// shared types, codes and helpers of the checked product accumulator
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = DataW / 2;

  // width select codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] REG_WIDTH_SELECT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SIGNED_MODE  = 1'b1;

  typedef struct packed {
    logic [1:0] width_select;
    logic       signed_mode;
  } cpa_cfg_t;

  typedef struct packed {
    logic             fits;
    logic [DataW-1:0] result;
  } cpa_mul_res_t;

  // mask of the selected operand width
  function automatic logic [DataW-1:0] sel_mask(input logic [1:0] wsel);
    logic [DataW-1:0] m;
    case (wsel)
      WSEL_8:  m = {{(DataW-8){1'b0}}, {8{1'b1}}};
      WSEL_16: m = {{(DataW-16){1'b0}}, {16{1'b1}}};
      WSEL_32: m = {{(DataW-32){1'b0}}, {32{1'b1}}};
      WSEL_64: m = {DataW{1'b1}};
      default: m = {DataW{1'b1}};
    endcase
    return m;
  endfunction

endpackage

// ===== src/cpa_if.sv =====
// ----------------------------------------------------------------------------
// cpa_in_if / cpa_out_if
// valid/ready channels of the checked product accumulator
// ----------------------------------------------------------------------------
interface cpa_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] operand;
  logic        operand_valid;
  logic        last;

  modport source (output valid, output operand, output operand_valid, output last,
                  input ready);
  modport sink   (input valid, input operand, input operand_valid, input last,
                  output ready);
endinterface

interface cpa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] product;
  logic        product_valid;

  modport source (output valid, output product, output product_valid, input ready);
  modport sink   (input valid, input product, input product_valid, output ready);
endinterface

// ===== src/cpa_mul.sv =====
// ----------------------------------------------------------------------------
// cpa_mul
// range-checked multiply of running product and operand at selected width
// ----------------------------------------------------------------------------
module cpa_mul
  import cpa_pkg::*;
(
  input  cpa_cfg_t         cfg_i,
  input  logic [DataW-1:0] acc_i,
  input  logic [DataW-1:0] opd_i,
  output cpa_mul_res_t     res_o
);

  logic [DataW-1:0] mask, lim, a_ext, b_ext, a_mag, b_mag, lo, res;
  logic             a_neg, b_neg, neg, a_sbit, b_sbit;
  logic [HalfW-1:0] al, ah, bl, bh;
  logic [DataW-1:0] p0, p1, p2;
  logic [DataW+1:0] sum;
  logic             ovf, zero, fit_u, fit_pos, fit_neg;

  assign mask = sel_mask(cfg_i.width_select);
  assign lim  = (mask >> 1) + {{(DataW-1){1'b0}}, 1'b1};

  // sign bit at the selected width
  always_comb begin
    case (cfg_i.width_select)
      WSEL_8:  begin a_sbit = acc_i[7];  b_sbit = opd_i[7];  end
      WSEL_16: begin a_sbit = acc_i[15]; b_sbit = opd_i[15]; end
      WSEL_32: begin a_sbit = acc_i[31]; b_sbit = opd_i[31]; end
      default: begin a_sbit = acc_i[63]; b_sbit = opd_i[63]; end
    endcase
  end

  assign a_ext = (acc_i & mask) | ((cfg_i.signed_mode && a_sbit) ? ~mask : '0);
  assign b_ext = (opd_i & mask) | ((cfg_i.signed_mode && b_sbit) ? ~mask : '0);
  assign a_neg = cfg_i.signed_mode & a_ext[DataW-1];
  assign b_neg = cfg_i.signed_mode & b_ext[DataW-1];
  assign neg   = a_neg ^ b_neg;
  assign a_mag = a_neg ? -a_ext : a_ext;
  assign b_mag = b_neg ? -b_ext : b_ext;

  assign {ah, al} = a_mag;
  assign {bh, bl} = b_mag;

  // three half-width partial products, high*high only matters as nonzero
  assign p0 = al * bl;
  assign p1 = al * bh;
  assign p2 = ah * bl;
  assign sum = {2'b00, p0}
             + {2'b00, p1[HalfW-1:0], {HalfW{1'b0}}}
             + {2'b00, p2[HalfW-1:0], {HalfW{1'b0}}};
  assign lo  = sum[DataW-1:0];
  assign ovf = ((|ah) && (|bh)) || (|p1[DataW-1:HalfW]) || (|p2[DataW-1:HalfW])
             || (|sum[DataW+1:DataW]);

  assign zero    = !ovf && (lo == '0);
  assign fit_u   = !ovf && ((lo & ~mask) == '0);
  assign fit_pos = !ovf && ((lo & ~(mask >> 1)) == '0);
  assign fit_neg = fit_pos || (!ovf && (lo == lim));

  assign res = neg ? -lo : lo;

  always_comb begin
    res_o.result = res & mask;
    if (zero) begin
      res_o.fits = 1'b1;
    end else if (!cfg_i.signed_mode) begin
      res_o.fits = fit_u;
    end else if (neg) begin
      res_o.fits = fit_neg;
    end else begin
      res_o.fits = fit_pos;
    end
  end

endmodule

// ===== src/checked_product_accumulator.sv =====
// ----------------------------------------------------------------------------
// checked_product_accumulator
// running product of a list of optional operands with overflow checking
// ----------------------------------------------------------------------------
//  channel  dir   payload                          word moves when
//  in_i     in    operand, operand_valid, last     in_i.valid && in_i.ready
//  out_o    out   product, product_valid           out_o.valid && out_o.ready
//  cfg      in    cfg_idx_i, cfg_wdata_i           cfg_we_i
//
//  one word per cycle sustained unless out stall holds a last word; a word
//  is folded into the running product as it leaves the input register (one
//  checked multiply per cycle, the running product loop sets that figure)
//  a list result enters the output register at the edge where its last word
//  leaves the input register; out stall blocks only a further last word
//  reset: product 1, all-good set, count 0, width 8 bits, unsigned
// ----------------------------------------------------------------------------
module checked_product_accumulator
  import cpa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cpa_in_if.sink              in_i,
  cpa_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // configuration registers
  cpa_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{width_select: WSEL_8, signed_mode: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH_SELECT: cfg_q.width_select <= cfg_wdata_i[1:0];
        REG_SIGNED_MODE:  cfg_q.signed_mode  <= cfg_wdata_i[0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // input register
  logic             in_vld_q;
  logic [DataW-1:0] in_opd_q;
  logic             in_ov_q, in_last_q;
  logic             adv, in_rdy;

  // a word leaves the input register unless it closes a list and the
  // output register still holds an untaken result
  assign adv    = in_vld_q && (!in_last_q || !out_o.valid || out_o.ready);
  assign in_rdy = !in_vld_q || adv;
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      in_opd_q  <= in_i.operand;
      in_ov_q   <= in_i.operand_valid;
      in_last_q <= in_i.last;
    end
  end

  // running state
  logic [DataW-1:0] prod_q, prod_d;
  logic             good_q, good_d;
  logic [1:0]       cnt_q, cnt_d;
  cpa_mul_res_t     mul;

  cpa_mul u_mul (
    .cfg_i (cfg_q),
    .acc_i (prod_q),
    .opd_i (in_opd_q),
    .res_o (mul)
  );

  // next state as if the word does not end the list
  always_comb begin
    cnt_d  = (cnt_q == 2'd3) ? cnt_q : cnt_q + 2'd1;
    prod_d = prod_q;
    good_d = good_q && in_ov_q;
    // after a failure the product stays, only the flag counts
    if (good_d) begin
      if (mul.fits) begin
        prod_d = mul.result;
      end else begin
        good_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= {{(DataW-1){1'b0}}, 1'b1};
      good_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (adv) begin
      if (in_last_q) begin
        prod_q <= {{(DataW-1){1'b0}}, 1'b1};
        good_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else begin
        prod_q <= prod_d;
        good_q <= good_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // output register
  logic             out_vld_q;
  logic [DataW-1:0] out_prod_q;
  logic             out_pv_q;
  logic             res_ok, emit;

  assign emit   = adv && in_last_q;
  assign res_ok = good_d && (cnt_d >= 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_prod_q <= res_ok ? (prod_d & sel_mask(cfg_q.width_select)) : '0;
      out_pv_q   <= res_ok;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.product       = out_prod_q;
  assign out_o.product_valid = out_pv_q;

  // a failed list always reports a zero product
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_pv_q |-> out_prod_q == '0)
    else $error("failed list result carries a nonzero product");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |-> !emit)
    else $error("output register overwritten while stalled");

  // the list state restarts after the closing word
  a_list_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> cnt_q == 2'd0 && good_q && prod_q == {{(DataW-1){1'b0}}, 1'b1})
    else $error("state not restarted after list end");

  // the count only grows inside a list
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_last_q |=> cnt_q != 2'd0)
    else $error("operand count lost inside a list");

endmodule
